// ----- src/clle_pkg.sv -----
// Shared types and constants for the circular linked list engine.
// No dependencies; used by clle_ctrl, clle_dp and circular_linked_list_engine_core.
`default_nettype none

package clle_pkg;

    // default sizes
    localparam int CAPACITY_DEF   = 256;
    localparam int VALUE_BITS_DEF = 32;

    // fixed port field widths
    localparam int CMD_W    = 2;
    localparam int INDEX_W  = 16;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;
    localparam int FPOS_W   = 8;
    localparam int ECOUNT_W = 9;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_FIND   = 2'd3
    } t_cmd;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_NO_POS    = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_POP_WAIT,
        S_ROUTE,
        S_WALK_START,
        S_WALK,
        S_INS_A,
        S_INS_B,
        S_FR_A,
        S_FR_B,
        S_RM_A,
        S_RM_RD,
        S_RM_TAKE,
        S_DONE
    } t_state;

    // datapath operations, one per cycle
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_FULL,
        OP_EMPTY,
        OP_RANGE,
        OP_POP_RD,
        OP_POP_FRESH,
        OP_POP_TAKE,
        OP_INS_ONLY,
        OP_WALK_START,
        OP_WALK_STEP,
        OP_READ_OUT,
        OP_FIND_HIT,
        OP_FIND_MISS,
        OP_INS_A,
        OP_INS_B,
        OP_FR_A,
        OP_FR_B,
        OP_RM_ONE,
        OP_RM_A,
        OP_RM_RD,
        OP_RM_TAKE,
        OP_EMIT
    } t_op;

    // datapath status toward the controller
    typedef struct packed {
        t_cmd cmd;
        logic count_zero;
        logic store_full;
        logic pop_mem;
        logic idx_in_range;
        logic walk_hit;
        logic find_end;
        logic find_match;
        logic one_left;
        logic need_refresh;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- src/clle_ctrl.sv -----
// Command sequencer of the circular linked list engine.
// Depends on clle_pkg; drives clle_dp through one operation code per cycle.
`default_nettype none

module clle_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire clle_pkg::t_dp_stat i_stat,
    output clle_pkg::t_op           o_op
);

    clle_pkg::t_state r_state;
    clle_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= clle_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            clle_pkg::S_IDLE: begin
                if (i_valid) n_state = clle_pkg::S_DISPATCH;
            end
            clle_pkg::S_DISPATCH: begin
                case (i_stat.cmd)
                    clle_pkg::CMD_INSERT: begin
                        if (i_stat.store_full)   n_state = clle_pkg::S_DONE;
                        else if (i_stat.pop_mem) n_state = clle_pkg::S_POP_WAIT;
                        else                     n_state = clle_pkg::S_ROUTE;
                    end
                    clle_pkg::CMD_REMOVE, clle_pkg::CMD_READ: begin
                        if (i_stat.count_zero || !i_stat.idx_in_range)
                            n_state = clle_pkg::S_DONE;
                        else
                            n_state = clle_pkg::S_WALK_START;
                    end
                    default: n_state = clle_pkg::S_WALK_START;
                endcase
            end
            clle_pkg::S_POP_WAIT: n_state = clle_pkg::S_ROUTE;
            clle_pkg::S_ROUTE: begin
                if (i_stat.count_zero)        n_state = clle_pkg::S_DONE;
                else if (i_stat.idx_in_range) n_state = clle_pkg::S_WALK_START;
                else                          n_state = clle_pkg::S_FR_A;
            end
            clle_pkg::S_WALK_START: n_state = clle_pkg::S_WALK;
            clle_pkg::S_WALK: begin
                if (i_stat.cmd == clle_pkg::CMD_FIND) begin
                    if (i_stat.find_end || i_stat.find_match) n_state = clle_pkg::S_DONE;
                end else if (i_stat.walk_hit) begin
                    case (i_stat.cmd)
                        clle_pkg::CMD_INSERT: n_state = clle_pkg::S_INS_A;
                        clle_pkg::CMD_REMOVE: begin
                            if (i_stat.one_left) n_state = clle_pkg::S_DONE;
                            else                 n_state = clle_pkg::S_RM_A;
                        end
                        default: n_state = clle_pkg::S_DONE;
                    endcase
                end
            end
            clle_pkg::S_INS_A: n_state = clle_pkg::S_INS_B;
            clle_pkg::S_INS_B: n_state = clle_pkg::S_DONE;
            clle_pkg::S_FR_A:  n_state = clle_pkg::S_FR_B;
            clle_pkg::S_FR_B:  n_state = clle_pkg::S_DONE;
            clle_pkg::S_RM_A: begin
                if (i_stat.need_refresh) n_state = clle_pkg::S_RM_RD;
                else                     n_state = clle_pkg::S_DONE;
            end
            clle_pkg::S_RM_RD:   n_state = clle_pkg::S_RM_TAKE;
            clle_pkg::S_RM_TAKE: n_state = clle_pkg::S_DONE;
            clle_pkg::S_DONE: begin
                if (i_stat.out_free) n_state = clle_pkg::S_IDLE;
            end
            default: n_state = clle_pkg::S_IDLE;
        endcase
    end

    // operation decode
    always_comb begin
        o_op    = clle_pkg::OP_NONE;
        o_stall = (r_state != clle_pkg::S_IDLE);
        case (r_state)
            clle_pkg::S_IDLE: begin
                if (i_valid) o_op = clle_pkg::OP_LATCH;
            end
            clle_pkg::S_DISPATCH: begin
                case (i_stat.cmd)
                    clle_pkg::CMD_INSERT: begin
                        if (i_stat.store_full)   o_op = clle_pkg::OP_FULL;
                        else if (i_stat.pop_mem) o_op = clle_pkg::OP_POP_RD;
                        else                     o_op = clle_pkg::OP_POP_FRESH;
                    end
                    clle_pkg::CMD_REMOVE, clle_pkg::CMD_READ: begin
                        if (i_stat.count_zero)         o_op = clle_pkg::OP_EMPTY;
                        else if (!i_stat.idx_in_range) o_op = clle_pkg::OP_RANGE;
                    end
                    default: o_op = clle_pkg::OP_NONE;
                endcase
            end
            clle_pkg::S_POP_WAIT: o_op = clle_pkg::OP_POP_TAKE;
            clle_pkg::S_ROUTE: begin
                if (i_stat.count_zero) o_op = clle_pkg::OP_INS_ONLY;
            end
            clle_pkg::S_WALK_START: o_op = clle_pkg::OP_WALK_START;
            clle_pkg::S_WALK: begin
                if (i_stat.cmd == clle_pkg::CMD_FIND) begin
                    if (i_stat.find_end)        o_op = clle_pkg::OP_FIND_MISS;
                    else if (i_stat.find_match) o_op = clle_pkg::OP_FIND_HIT;
                    else                        o_op = clle_pkg::OP_WALK_STEP;
                end else if (i_stat.walk_hit) begin
                    case (i_stat.cmd)
                        clle_pkg::CMD_READ: o_op = clle_pkg::OP_READ_OUT;
                        clle_pkg::CMD_REMOVE: begin
                            if (i_stat.one_left) o_op = clle_pkg::OP_RM_ONE;
                        end
                        default: o_op = clle_pkg::OP_NONE;
                    endcase
                end else begin
                    o_op = clle_pkg::OP_WALK_STEP;
                end
            end
            clle_pkg::S_INS_A:   o_op = clle_pkg::OP_INS_A;
            clle_pkg::S_INS_B:   o_op = clle_pkg::OP_INS_B;
            clle_pkg::S_FR_A:    o_op = clle_pkg::OP_FR_A;
            clle_pkg::S_FR_B:    o_op = clle_pkg::OP_FR_B;
            clle_pkg::S_RM_A:    o_op = clle_pkg::OP_RM_A;
            clle_pkg::S_RM_RD:   o_op = clle_pkg::OP_RM_RD;
            clle_pkg::S_RM_TAKE: o_op = clle_pkg::OP_RM_TAKE;
            clle_pkg::S_DONE: begin
                if (i_stat.out_free) o_op = clle_pkg::OP_EMIT;
            end
            default: o_op = clle_pkg::OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

// ----- src/clle_dp.sv -----
// Datapath of the circular linked list engine: slot memories, free stack,
// list registers and the result register. Depends on clle_pkg; run by clle_ctrl.
`default_nettype none

module clle_dp #(
    parameter int CAPACITY   = clle_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = clle_pkg::VALUE_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire clle_pkg::t_op                       i_op,
    output clle_pkg::t_dp_stat                       o_stat,
    input  wire logic [clle_pkg::CMD_W-1:0]          i_cmd,
    input  wire logic [clle_pkg::INDEX_W-1:0]        i_index,
    input  wire logic signed [clle_pkg::DATA_W-1:0]  i_value,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [clle_pkg::STATUS_W-1:0]            o_status,
    output logic signed [clle_pkg::DATA_W-1:0]       o_read_value,
    output logic [clle_pkg::FPOS_W-1:0]              o_found_position,
    output logic [clle_pkg::ECOUNT_W-1:0]            o_element_count,
    output logic signed [clle_pkg::DATA_W-1:0]       o_first_value,
    output logic signed [clle_pkg::DATA_W-1:0]       o_last_value
);

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int VB = VALUE_BITS;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    // slot memories and free stack
    logic [VB-1:0] r_val_mem [CAPACITY];
    logic [SW-1:0] r_nxt_mem [CAPACITY];
    logic [SW-1:0] r_prv_mem [CAPACITY];
    logic [SW-1:0] r_stk_mem [CAPACITY];
    logic [VB-1:0] r_val_q;
    logic [SW-1:0] r_nxt_q;
    logic [SW-1:0] r_prv_q;
    logic [SW-1:0] r_stk_q;

    // list control
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_free_top;
    logic [CW-1:0] r_lwm;
    logic [SW-1:0] r_head;
    logic [SW-1:0] r_tail;
    logic          r_ov;

    // command payload and work registers
    clle_pkg::t_cmd             r_cmd;
    logic [clle_pkg::INDEX_W-1:0] r_index;
    logic [VB-1:0]              r_key;
    clle_pkg::t_status          r_status;
    logic [clle_pkg::DATA_W-1:0] r_rd;
    logic [clle_pkg::FPOS_W-1:0] r_fpos;
    logic [SW-1:0]              r_slot;
    logic [SW-1:0]              r_new;
    logic [CW-1:0]              r_i;
    logic [VB-1:0]              r_hv;
    logic [VB-1:0]              r_tv;
    logic                       r_fix_head;

    // result register
    logic [clle_pkg::STATUS_W-1:0] r_o_status;
    logic [clle_pkg::DATA_W-1:0]   r_o_rd;
    logic [clle_pkg::FPOS_W-1:0]   r_o_fpos;
    logic [clle_pkg::ECOUNT_W-1:0] r_o_count;
    logic [clle_pkg::DATA_W-1:0]   r_o_first;
    logic [clle_pkg::DATA_W-1:0]   r_o_last;

    logic [VB-1:0] key_in;
    logic [63:0]   in_wide;
    logic [63:0]   rd_wide;
    logic [63:0]   hv_wide;
    logic [63:0]   tv_wide;
    logic [CW-1:0] top_m1;
    logic [SW-1:0] fresh_slot;
    logic [SW-1:0] rd_addr;
    logic          rd_en;
    logic          val_we;
    logic          nxt_we;
    logic          prv_we;
    logic [SW-1:0] nxt_wa;
    logic [SW-1:0] nxt_wd;
    logic [SW-1:0] prv_wa;
    logic [SW-1:0] prv_wd;
    logic          push_we;
    logic          out_free;

    // value width conversion, sign extending or cutting
    assign in_wide = 64'(i_value);
    assign key_in  = VB'(in_wide);
    assign rd_wide = 64'($signed(r_val_q));
    assign hv_wide = 64'($signed(r_hv));
    assign tv_wide = 64'($signed(r_tv));

    assign top_m1     = r_free_top - ONE_C;
    assign fresh_slot = SW'(CAP_C - r_free_top);
    assign out_free   = !r_ov || !i_stall;
    assign push_we    = ((i_op == clle_pkg::OP_RM_A) || (i_op == clle_pkg::OP_RM_ONE))
                        && (r_free_top < CAP_C);

    // status toward the controller
    always_comb begin
        o_stat.cmd          = r_cmd;
        o_stat.count_zero   = (r_count == '0);
        o_stat.store_full   = (r_free_top == '0) || (r_count >= CAP_C);
        o_stat.pop_mem      = (r_free_top > r_lwm);
        o_stat.idx_in_range = (r_index < clle_pkg::INDEX_W'(r_count));
        o_stat.walk_hit     = (clle_pkg::INDEX_W'(r_i) == r_index);
        o_stat.find_end     = (r_i >= r_count);
        o_stat.find_match   = (r_val_q == r_key);
        o_stat.one_left     = (r_count == ONE_C);
        o_stat.need_refresh = (r_slot == r_head) || (r_slot == r_tail);
        o_stat.out_free     = out_free;
    end

    // read address select
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_head;
        case (i_op)
            clle_pkg::OP_WALK_START: begin
                rd_en   = 1'b1;
                rd_addr = r_head;
            end
            clle_pkg::OP_WALK_STEP: begin
                rd_en   = 1'b1;
                rd_addr = r_nxt_q;
            end
            clle_pkg::OP_RM_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_fix_head ? r_head : r_tail;
            end
            default: rd_en = 1'b0;
        endcase
    end

    // link write select
    always_comb begin
        val_we = 1'b0;
        nxt_we = 1'b0;
        prv_we = 1'b0;
        nxt_wa = r_new;
        nxt_wd = r_new;
        prv_wa = r_new;
        prv_wd = r_new;
        case (i_op)
            clle_pkg::OP_INS_ONLY: begin
                val_we = 1'b1;
                nxt_we = 1'b1;
                prv_we = 1'b1;
            end
            clle_pkg::OP_INS_A: begin
                val_we = 1'b1;
                nxt_we = 1'b1;
                nxt_wd = r_nxt_q;
                prv_we = 1'b1;
                prv_wa = r_nxt_q;
            end
            clle_pkg::OP_INS_B: begin
                prv_we = 1'b1;
                prv_wd = r_slot;
                nxt_we = 1'b1;
                nxt_wa = r_slot;
            end
            clle_pkg::OP_FR_A: begin
                val_we = 1'b1;
                nxt_we = 1'b1;
                nxt_wd = r_head;
                prv_we = 1'b1;
                prv_wa = r_head;
            end
            clle_pkg::OP_FR_B: begin
                prv_we = 1'b1;
                prv_wd = r_tail;
                nxt_we = 1'b1;
                nxt_wa = r_tail;
            end
            clle_pkg::OP_RM_A: begin
                nxt_we = 1'b1;
                nxt_wa = r_prv_q;
                nxt_wd = r_nxt_q;
                prv_we = 1'b1;
                prv_wa = r_nxt_q;
                prv_wd = r_prv_q;
            end
            default: val_we = 1'b0;
        endcase
    end

    // slot memories
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_val_q <= r_val_mem[rd_addr];
            r_nxt_q <= r_nxt_mem[rd_addr];
            r_prv_q <= r_prv_mem[rd_addr];
        end
        if (val_we) r_val_mem[r_new] <= r_key;
        if (nxt_we) r_nxt_mem[nxt_wa] <= nxt_wd;
        if (prv_we) r_prv_mem[prv_wa] <= prv_wd;
    end

    // free stack memory
    always_ff @(posedge i_clk) begin
        if (i_op == clle_pkg::OP_POP_RD) r_stk_q <= r_stk_mem[SW'(top_m1)];
        if (push_we) r_stk_mem[SW'(r_free_top)] <= r_slot;
    end

    // list control registers; stack entries below the low-water mark were never written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_free_top <= CAP_C;
            r_lwm      <= CAP_C;
            r_head     <= '0;
            r_tail     <= '0;
            r_ov       <= 1'b0;
        end else begin
            case (i_op)
                clle_pkg::OP_POP_RD: r_free_top <= top_m1;
                clle_pkg::OP_POP_FRESH: begin
                    r_free_top <= top_m1;
                    r_lwm      <= top_m1;
                end
                clle_pkg::OP_INS_ONLY: begin
                    r_head  <= r_new;
                    r_tail  <= r_new;
                    r_count <= r_count + ONE_C;
                end
                clle_pkg::OP_INS_B: begin
                    if (r_slot == r_tail) r_tail <= r_new;
                    r_count <= r_count + ONE_C;
                end
                clle_pkg::OP_FR_B: begin
                    r_head  <= r_new;
                    r_count <= r_count + ONE_C;
                end
                clle_pkg::OP_RM_ONE: begin
                    r_head  <= '0;
                    r_tail  <= '0;
                    r_count <= r_count - ONE_C;
                    if (push_we) r_free_top <= r_free_top + ONE_C;
                end
                clle_pkg::OP_RM_A: begin
                    if (r_slot == r_head) r_head <= r_nxt_q;
                    if (r_slot == r_tail) r_tail <= r_prv_q;
                    r_count <= r_count - ONE_C;
                    if (push_we) r_free_top <= r_free_top + ONE_C;
                end
                default: r_count <= r_count;
            endcase
            if (i_op == clle_pkg::OP_EMIT) r_ov <= 1'b1;
            else if (!i_stall)             r_ov <= 1'b0;
        end
    end

    // command payload, walk cursor and end values
    always_ff @(posedge i_clk) begin
        case (i_op)
            clle_pkg::OP_LATCH: begin
                r_cmd    <= clle_pkg::t_cmd'(i_cmd);
                r_index  <= i_index;
                r_key    <= key_in;
                r_status <= clle_pkg::ST_OK;
                r_rd     <= '0;
                r_fpos   <= '0;
            end
            clle_pkg::OP_FULL:      r_status <= clle_pkg::ST_FULL;
            clle_pkg::OP_EMPTY:     r_status <= clle_pkg::ST_EMPTY;
            clle_pkg::OP_RANGE:     r_status <= clle_pkg::ST_NO_POS;
            clle_pkg::OP_POP_FRESH: r_new <= fresh_slot;
            clle_pkg::OP_POP_TAKE:  r_new <= r_stk_q;
            clle_pkg::OP_INS_ONLY: begin
                r_hv <= r_key;
                r_tv <= r_key;
            end
            clle_pkg::OP_WALK_START: begin
                r_slot <= r_head;
                r_i    <= '0;
            end
            clle_pkg::OP_WALK_STEP: begin
                r_slot <= r_nxt_q;
                r_i    <= r_i + ONE_C;
            end
            clle_pkg::OP_READ_OUT:  r_rd <= rd_wide[clle_pkg::DATA_W-1:0];
            clle_pkg::OP_FIND_HIT:  r_fpos <= clle_pkg::FPOS_W'(r_i);
            clle_pkg::OP_FIND_MISS: r_status <= clle_pkg::ST_NOT_FOUND;
            clle_pkg::OP_INS_B: begin
                if (r_slot == r_tail) r_tv <= r_key;
            end
            clle_pkg::OP_FR_B:  r_hv <= r_key;
            clle_pkg::OP_RM_A:  r_fix_head <= (r_slot == r_head);
            clle_pkg::OP_RM_TAKE: begin
                if (r_fix_head) r_hv <= r_val_q;
                else            r_tv <= r_val_q;
            end
            clle_pkg::OP_EMIT: begin
                r_o_status <= r_status;
                r_o_rd     <= r_rd;
                r_o_fpos   <= r_fpos;
                r_o_count  <= clle_pkg::ECOUNT_W'(r_count);
                r_o_first  <= (r_count != '0) ? hv_wide[clle_pkg::DATA_W-1:0] : '0;
                r_o_last   <= (r_count != '0) ? tv_wide[clle_pkg::DATA_W-1:0] : '0;
            end
            default: r_fix_head <= r_fix_head;
        endcase
    end

    assign o_valid          = r_ov;
    assign o_status         = r_o_status;
    assign o_read_value     = r_o_rd;
    assign o_found_position = r_o_fpos;
    assign o_element_count  = r_o_count;
    assign o_first_value    = r_o_first;
    assign o_last_value     = r_o_last;

    // every slot is either live or on the free stack once a command completes
    a_slot_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == clle_pkg::OP_EMIT) |->
        ((CW+1)'(r_count) + (CW+1)'(r_free_top) == (CW+1)'(CAPACITY)))
        else $error("live plus free slots differ from capacity");

    // the never-written region of the free stack lies below the stack top
    a_lwm_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lwm <= r_free_top)
        else $error("free stack low-water mark above stack top");

    // a ring of one element starts and ends on the same slot
    a_single_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == clle_pkg::OP_EMIT) && (r_count == ONE_C) |-> (r_head == r_tail))
        else $error("single element list with head and tail apart");

    // a result is loaded only into a free output register
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == clle_pkg::OP_EMIT) |-> out_free)
        else $error("result overwrites an item not yet taken");

    // a stack read never happens on an empty free stack
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == clle_pkg::OP_POP_RD) |-> (r_free_top != '0))
        else $error("free stack popped while empty");

endmodule

`default_nettype wire

// ----- src/circular_linked_list_engine_core.sv -----
// Top level of the circular linked list engine: sequencer plus datapath.
// Depends on clle_pkg, clle_ctrl and clle_dp.
//
// Bounded doubly linked circular list of up to CAPACITY signed values with a
// free-slot stack. One command is handled at a time and gives one result item
// carrying status, read value, found position, element count and first/last
// values. Taking an insert slot from the free stack memory rather than the
// never-used region adds a wait state for the stack read. Commands that
// name a position walk the ring one element per cycle through the single read
// port of the link memory, and a find that misses walks the whole list. A
// remove at either end of the list also reads the new end slot to refresh the
// first or last value. A new item is taken only once the result of the
// previous one is in the output register, so a stalled output holds the
// engine. No clearing pass runs after reset; the free stack tracks its
// never-used region with a low-water mark.
`default_nettype none

module circular_linked_list_engine_core #(
    parameter int CAPACITY   = clle_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = clle_pkg::VALUE_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [clle_pkg::CMD_W-1:0]          i_cmd,
    input  wire logic [clle_pkg::INDEX_W-1:0]        i_index,
    input  wire logic signed [clle_pkg::DATA_W-1:0]  i_value,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [clle_pkg::STATUS_W-1:0]            o_status,
    output logic signed [clle_pkg::DATA_W-1:0]       o_read_value,
    output logic [clle_pkg::FPOS_W-1:0]              o_found_position,
    output logic [clle_pkg::ECOUNT_W-1:0]            o_element_count,
    output logic signed [clle_pkg::DATA_W-1:0]       o_first_value,
    output logic signed [clle_pkg::DATA_W-1:0]       o_last_value
);

    clle_pkg::t_op      op;
    clle_pkg::t_dp_stat dp_stat;

    // command sequencer
    clle_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (dp_stat),
        .o_op    (op)
    );

    // list storage and result register
    clle_dp #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (op),
        .o_stat           (dp_stat),
        .i_cmd            (i_cmd),
        .i_index          (i_index),
        .i_value          (i_value),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_read_value     (o_read_value),
        .o_found_position (o_found_position),
        .o_element_count  (o_element_count),
        .o_first_value    (o_first_value),
        .o_last_value     (o_last_value)
    );

endmodule

`default_nettype wire
